[rtl/hrst_pkg.sv]
// Shared types and constants for the hit record slot table.
// Holds the transaction structs, the in-chain packet and the action/status codes.
// No dependencies.
package hrst_pkg;

  localparam int ID_W    = 31;
  localparam int SLOT_W  = 8;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 16;

  localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_ADD          = 3'd0,
    ACT_FIND         = 3'd1,
    ACT_READ_ID      = 3'd2,
    ACT_RELEASE_ID   = 3'd3,
    ACT_READ_SLOT    = 3'd4,
    ACT_RELEASE_SLOT = 3'd5
  } hrst_action_e;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]                action;
    logic [ID_W-1:0]           record_id;
    logic [WORD_W-1:0]         object_id;
    logic [WORD_W-1:0]         attack_flags;
    logic [WORD_W-1:0]         skill_code;
    logic signed [COUNT_W-1:0] hit_limit;
    logic [SLOT_W-1:0]         slot_number;
    logic                      force_req;
  } hrst_in_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [ID_W-1:0]           result_id;
    logic [SLOT_W-1:0]         result_slot;
    logic [WORD_W-1:0]         result_object;
    logic [WORD_W-1:0]         result_flags;
    logic [WORD_W-1:0]         result_skill;
    logic signed [COUNT_W-1:0] result_count;
  } hrst_out_t;

  // Request walking down the cell row, with the response built up on the way.
  typedef struct packed {
    logic      valid;
    logic      done;
    hrst_in_t  req;
    hrst_out_t rsp;
  } hrst_pkt_t;

endpackage

[rtl/hit_record_slot_table_unit.sv]
// Hit record slot table: a row of SLOTS cells that a request packet walks through.
// The input stalls while a transaction is in the row or a result is pending; the packet steps one cell a cycle.
// A result register plus one pending register let the next transaction in while a result waits.
// Reset (asynchronous, active low) frees every slot, zeroes the id counter, empties the row.
// Depends on hrst_pkg and hrst_cell.
module hit_record_slot_table_unit #(
  parameter int SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hrst_pkg::hrst_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hrst_pkg::hrst_out_t out_data_o
);

  hrst_pkg::hrst_pkt_t chain [SLOTS+1];
  hrst_pkg::hrst_pkt_t inj_q, inj_d;
  hrst_pkg::hrst_out_t out_q, out_d, pend_q, pend_d, end_rsp;

  logic [hrst_pkg::ID_W-1:0] counter_q, counter_d;
  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  logic in_accept, out_take, capture, table_full;

  assign in_stall_o = busy_q | pend_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign capture    = chain[SLOTS].valid;
  assign table_full = capture && !chain[SLOTS].done
                      && (chain[SLOTS].req.action == hrst_pkg::ACT_ADD);

  // resolve auto-assigned ids before the packet enters the row
  always_comb begin
    counter_d = counter_q;
    inj_d     = '0;
    if (in_accept) begin
      inj_d.valid      = 1'b1;
      inj_d.req        = in_data_i;
      inj_d.rsp.status = hrst_pkg::ST_MISS;
      if (in_data_i.action == hrst_pkg::ACT_ADD && in_data_i.record_id == '0) begin
        counter_d           = (counter_q == hrst_pkg::ID_MAX) ? hrst_pkg::ID_W'(1)
                                                              : counter_q + 1'b1;
        inj_d.req.record_id = counter_d;
      end
    end
  end

  assign chain[0] = inj_q;

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    hrst_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clear_i(table_full),
      .pkt_i  (chain[k]),
      .pkt_o  (chain[k+1])
    );
  end

  always_comb begin
    end_rsp = chain[SLOTS].rsp;
    if (table_full) begin
      end_rsp        = '0;
      end_rsp.status = hrst_pkg::ST_FULL;
    end
  end

  always_comb begin
    busy_d       = busy_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;

    if (in_accept) begin
      busy_d = 1'b1;
    end

    if (out_take) begin
      out_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_d        = pend_q;
        out_valid_d  = 1'b1;
        pend_valid_d = 1'b0;
      end
    end

    if (capture) begin
      busy_d = 1'b0;
      // park the result when the output register stays occupied
      if (!out_valid_q || out_take) begin
        out_d       = end_rsp;
        out_valid_d = 1'b1;
      end else begin
        pend_d       = end_rsp;
        pend_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_q        <= '0;
      counter_q    <= '0;
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      inj_q        <= inj_d;
      counter_q    <= counter_d;
      busy_q       <= busy_d;
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_end_only_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    capture |-> busy_q)
    else $error("packet left the cell row with no transaction in flight");

  a_accept_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q)
    else $error("accepted transaction not marked in flight");

  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending result held while output register is empty");

  a_full_is_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == hrst_pkg::ST_FULL) |->
      (out_q.result_id == '0 && out_q.result_slot == '0))
    else $error("table-full result carries record fields");

endmodule

[rtl/hrst_cell.sv]
// One slot of the hit record table: holds the record and acts on a passing request.
// Registers the request packet each cycle and hands it to the next cell.
// Depends on hrst_pkg.
module hrst_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  hrst_pkg::hrst_pkt_t pkt_i,
  output hrst_pkg::hrst_pkt_t pkt_o
);

  localparam logic [hrst_pkg::SLOT_W-1:0] SlotIdx = hrst_pkg::SLOT_W'(CELL_IDX);

  hrst_pkg::hrst_pkt_t pkt_q, pkt_d;

  logic [hrst_pkg::ID_W-1:0]           id_q, id_d;
  logic [hrst_pkg::WORD_W-1:0]         object_q, object_d;
  logic [hrst_pkg::WORD_W-1:0]         flags_q, flags_d;
  logic [hrst_pkg::WORD_W-1:0]         skill_q, skill_d;
  logic signed [hrst_pkg::COUNT_W-1:0] count_q, count_d;

  logic signed [hrst_pkg::COUNT_W-1:0] count_dec;
  logic live, id_match, slot_sel, active;
  logic do_add, do_find, do_emit, do_release;

  always_comb begin
    pkt_d    = pkt_i;
    id_d     = id_q;
    object_d = object_q;
    flags_d  = flags_q;
    skill_d  = skill_q;
    count_d  = count_q;

    count_dec = count_q - 16'sd1;
    live      = (id_q != '0);
    id_match  = (pkt_i.req.record_id != '0) && (id_q == pkt_i.req.record_id);
    slot_sel  = live && (pkt_i.req.slot_number == SlotIdx);
    active    = pkt_i.valid && !pkt_i.done;

    do_add     = 1'b0;
    do_find    = 1'b0;
    do_emit    = 1'b0;
    do_release = 1'b0;
    case (pkt_i.req.action)
      hrst_pkg::ACT_ADD:          do_add     = active && !live;
      hrst_pkg::ACT_FIND:         do_find    = active && id_match;
      hrst_pkg::ACT_READ_ID:      do_emit    = active && id_match;
      hrst_pkg::ACT_RELEASE_ID:   do_release = active && id_match;
      hrst_pkg::ACT_READ_SLOT:    do_emit    = active && slot_sel;
      hrst_pkg::ACT_RELEASE_SLOT: do_release = active && slot_sel;
      default: ;
    endcase

    if (do_add) begin
      id_d     = pkt_i.req.record_id;
      object_d = pkt_i.req.object_id;
      flags_d  = pkt_i.req.attack_flags;
      skill_d  = pkt_i.req.skill_code;
      count_d  = pkt_i.req.hit_limit;
    end

    if (do_add || do_find) begin
      pkt_d.done             = 1'b1;
      pkt_d.rsp.status       = hrst_pkg::ST_OK;
      pkt_d.rsp.result_id    = pkt_i.req.record_id;
      pkt_d.rsp.result_slot  = SlotIdx;
    end

    if (do_emit) begin
      pkt_d.done              = 1'b1;
      pkt_d.rsp.status        = hrst_pkg::ST_OK;
      pkt_d.rsp.result_id     = id_q;
      pkt_d.rsp.result_slot   = SlotIdx;
      pkt_d.rsp.result_object = object_q;
      pkt_d.rsp.result_flags  = flags_q;
      pkt_d.rsp.result_skill  = skill_q;
      pkt_d.rsp.result_count  = count_q;
    end

    if (do_release) begin
      count_d                = count_dec;
      pkt_d.done             = 1'b1;
      pkt_d.rsp.status       = hrst_pkg::ST_OK;
      pkt_d.rsp.result_id    = id_q;
      pkt_d.rsp.result_slot  = SlotIdx;
      pkt_d.rsp.result_count = count_dec;
      // free the slot when the count runs out or on a forced release
      if (count_dec == '0 || pkt_i.req.force_req) begin
        id_d = '0;
      end
    end

    if (clear_i) begin
      id_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
      id_q  <= '0;
    end else begin
      pkt_q <= pkt_d;
      id_q  <= id_d;
    end
  end

  always_ff @(posedge clk_i) begin
    object_q <= object_d;
    flags_q  <= flags_d;
    skill_q  <= skill_d;
    count_q  <= count_d;
  end

  assign pkt_o = pkt_q;

endmodule

[bench/hrst_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the hit record slot table: keeps its own copy of the slots and id counter,
// predicts the response to every accepted request and compares it field by field.
// Depends on hrst_pkg.
module hrst_checker #(
  parameter int SLOTS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  hrst_pkg::hrst_in_t  in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  hrst_pkg::hrst_out_t out_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  logic [hrst_pkg::ID_W-1:0]    tbl_id     [SLOTS];
  logic [hrst_pkg::WORD_W-1:0]  tbl_object [SLOTS];
  logic [hrst_pkg::WORD_W-1:0]  tbl_flags  [SLOTS];
  logic [hrst_pkg::WORD_W-1:0]  tbl_skill  [SLOTS];
  logic [hrst_pkg::COUNT_W-1:0] tbl_count  [SLOTS];
  logic [hrst_pkg::ID_W-1:0]    auto_id;
  hrst_pkg::hrst_out_t          expected_rsp[$];
  int                           fail_total = 0;

  assign fail_count_o = fail_total;

  task automatic report_failure(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    fail_total++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_id[i]     = '0;
      tbl_object[i] = '0;
      tbl_flags[i]  = '0;
      tbl_skill[i]  = '0;
      tbl_count[i]  = '0;
    end
  endfunction

  // Lowest slot holding id; id zero never matches.
  function automatic int lookup_id(input logic [hrst_pkg::ID_W-1:0] id);
    int hit;
    hit = -1;
    if (id != '0) begin
      for (int i = SLOTS - 1; i >= 0; i--) begin
        if (tbl_id[i] == id) hit = i;
      end
    end
    return hit;
  endfunction

  function automatic hrst_pkg::hrst_out_t read_entry(input int idx);
    hrst_pkg::hrst_out_t rsp;
    rsp               = '0;
    rsp.status        = hrst_pkg::ST_OK;
    rsp.result_id     = tbl_id[idx];
    rsp.result_slot   = hrst_pkg::SLOT_W'(idx);
    rsp.result_object = tbl_object[idx];
    rsp.result_flags  = tbl_flags[idx];
    rsp.result_skill  = tbl_skill[idx];
    rsp.result_count  = tbl_count[idx];
    return rsp;
  endfunction

  // Decrement with 16-bit wrap; free on zero or on force.
  function automatic hrst_pkg::hrst_out_t release_entry(input int idx, input logic force_it);
    hrst_pkg::hrst_out_t rsp;
    rsp              = '0;
    tbl_count[idx]   = tbl_count[idx] - 1'b1;
    rsp.status       = hrst_pkg::ST_OK;
    rsp.result_id    = tbl_id[idx];
    rsp.result_slot  = hrst_pkg::SLOT_W'(idx);
    rsp.result_count = tbl_count[idx];
    if (tbl_count[idx] == '0 || force_it) tbl_id[idx] = '0;
    return rsp;
  endfunction

  function automatic hrst_pkg::hrst_out_t table_response(input hrst_pkg::hrst_in_t req);
    hrst_pkg::hrst_out_t       rsp;
    logic [hrst_pkg::ID_W-1:0] new_id;
    int                        idx;
    rsp        = '0;
    rsp.status = hrst_pkg::ST_MISS;
    case (req.action)
      hrst_pkg::ACT_ADD: begin
        new_id = req.record_id;
        if (new_id == '0) begin
          auto_id = (auto_id == hrst_pkg::ID_MAX) ? hrst_pkg::ID_W'(1) : auto_id + 1'b1;
          new_id  = auto_id;
        end
        idx = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (tbl_id[i] == '0) idx = i;
        end
        if (idx >= 0) begin
          tbl_id[idx]     = new_id;
          tbl_object[idx] = req.object_id;
          tbl_flags[idx]  = req.attack_flags;
          tbl_skill[idx]  = req.skill_code;
          tbl_count[idx]  = req.hit_limit;
          rsp.status      = hrst_pkg::ST_OK;
          rsp.result_id   = new_id;
          rsp.result_slot = hrst_pkg::SLOT_W'(idx);
        end else begin
          // No free slot: wipe the table and report full.
          clear_table();
          rsp.status = hrst_pkg::ST_FULL;
        end
      end
      hrst_pkg::ACT_FIND: begin
        idx = lookup_id(req.record_id);
        if (idx >= 0) begin
          rsp.status      = hrst_pkg::ST_OK;
          rsp.result_id   = req.record_id;
          rsp.result_slot = hrst_pkg::SLOT_W'(idx);
        end
      end
      hrst_pkg::ACT_READ_ID: begin
        idx = lookup_id(req.record_id);
        if (idx >= 0) rsp = read_entry(idx);
      end
      hrst_pkg::ACT_RELEASE_ID: begin
        idx = lookup_id(req.record_id);
        if (idx >= 0) rsp = release_entry(idx, req.force_req);
      end
      hrst_pkg::ACT_READ_SLOT: begin
        if (req.slot_number < SLOTS) begin
          if (tbl_id[req.slot_number] != '0) rsp = read_entry(int'(req.slot_number));
        end
      end
      hrst_pkg::ACT_RELEASE_SLOT: begin
        if (req.slot_number < SLOTS) begin
          if (tbl_id[req.slot_number] != '0) begin
            rsp = release_entry(int'(req.slot_number), req.force_req);
          end
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic compare_result(input hrst_pkg::hrst_out_t got,
                                input hrst_pkg::hrst_out_t want);
    if (got.status !== want.status)
      report_failure($sformatf("status got %0d expected %0d", got.status, want.status));
    if (got.result_id !== want.result_id)
      report_failure($sformatf("result_id got %h expected %h", got.result_id, want.result_id));
    if (got.result_slot !== want.result_slot)
      report_failure($sformatf("result_slot got %0d expected %0d",
                               got.result_slot, want.result_slot));
    if (got.result_object !== want.result_object)
      report_failure($sformatf("result_object got %h expected %h",
                               got.result_object, want.result_object));
    if (got.result_flags !== want.result_flags)
      report_failure($sformatf("result_flags got %h expected %h",
                               got.result_flags, want.result_flags));
    if (got.result_skill !== want.result_skill)
      report_failure($sformatf("result_skill got %h expected %h",
                               got.result_skill, want.result_skill));
    if (got.result_count !== want.result_count)
      report_failure($sformatf("result_count got %h expected %h",
                               got.result_count, want.result_count));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_table();
      auto_id = '0;
      expected_rsp.delete();
      pending_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsp.push_back(table_response(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp.size() == 0) report_failure("response with no request outstanding");
        else compare_result(out_data_i, expected_rsp.pop_front());
      end
      pending_o <= expected_rsp.size();
    end
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// Top of the slot table bench: clock, reset, request stimulus and output back-pressure.
// Depends on hrst_pkg, hit_record_slot_table_unit and hrst_checker.
module testbench;

  localparam int SLOTS       = 32;
  localparam int PHASE_ITEMS = 388;
  localparam int BURST_ITEMS = 50;
  localparam int CYCLE_LIMIT = 1000000;

  // Action codes the block leaves unused.
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  hrst_pkg::hrst_in_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  hrst_pkg::hrst_out_t out_data_o;

  int                        fail_count;
  int                        pending;
  int                        idle_mode;
  int                        cycle_count = 0;
  logic [hrst_pkg::ID_W-1:0] recent_ids[$];

  hit_record_slot_table_unit #(.SLOTS(SLOTS)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  hrst_checker #(.SLOTS(SLOTS)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic sender_idle();
    return (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 85) ||
           (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14);
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 85) ||
                   (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 14);
  end

  // Hold valid and payload until the transaction is taken.
  task automatic send_item(input hrst_pkg::hrst_in_t item);
    @(negedge clk_i);
    while (sender_idle()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic hrst_pkg::hrst_in_t request(
    input logic [2:0]                   action,
    input logic [hrst_pkg::ID_W-1:0]    id,
    input logic [hrst_pkg::SLOT_W-1:0]  slot,
    input logic [hrst_pkg::COUNT_W-1:0] limit,
    input logic                         force_it,
    input logic [hrst_pkg::WORD_W-1:0]  word
  );
    hrst_pkg::hrst_in_t req;
    req.action       = action;
    req.record_id    = id;
    req.object_id    = word;
    req.attack_flags = ~word;
    req.skill_code   = word ^ 32'h5A5A_C3C3;
    req.hit_limit    = limit;
    req.slot_number  = slot;
    req.force_req    = force_it;
    return req;
  endfunction

  function automatic logic [hrst_pkg::ID_W-1:0] pick_id();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return '0;
    if (roll < 70 && recent_ids.size() > 0)
      return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    if (roll < 95) return hrst_pkg::ID_W'($urandom_range(1, 48));
    return hrst_pkg::ID_W'($urandom() >> 1);
  endfunction

  function automatic hrst_pkg::hrst_in_t random_request(input int add_pct);
    hrst_pkg::hrst_in_t req;
    req.record_id    = pick_id();
    req.object_id    = $urandom();
    req.attack_flags = $urandom();
    req.skill_code   = $urandom();
    req.hit_limit    = ($urandom_range(0, 99) < 70)
                       ? hrst_pkg::COUNT_W'($urandom_range(0, 3))
                       : hrst_pkg::COUNT_W'($urandom());
    req.slot_number  = ($urandom_range(0, 99) < 80)
                       ? hrst_pkg::SLOT_W'($urandom_range(0, SLOTS - 1))
                       : hrst_pkg::SLOT_W'($urandom_range(0, 255));
    req.force_req    = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < add_pct) begin
      req.action = hrst_pkg::ACT_ADD;
    end else begin
      case ($urandom_range(0, 15))
        0, 1, 2:    req.action = hrst_pkg::ACT_FIND;
        3, 4, 5:    req.action = hrst_pkg::ACT_READ_ID;
        6, 7, 8:    req.action = hrst_pkg::ACT_RELEASE_ID;
        9, 10:      req.action = hrst_pkg::ACT_READ_SLOT;
        11, 12, 13: req.action = hrst_pkg::ACT_RELEASE_SLOT;
        14:         req.action = ACT_SPARE_6;
        default:    req.action = ACT_SPARE_7;
      endcase
    end
    return req;
  endfunction

  initial begin
    hrst_pkg::hrst_in_t req;
    int                 sent;
    int                 add_pct;
    int                 phase_modes[4];
    int                 add_mix[3];
    phase_modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    add_mix     = '{85, 45, 15};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    idle_mode   = IDLE_NONE;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-table misses, extremes, duplicates, wraps, bad slots, spare actions.
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_FIND, '0, '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_ADD, '0, '0, 16'h7FFF, 1'b0, 32'hFFFF_FFFF));
    send_item(request(hrst_pkg::ACT_ADD, hrst_pkg::ID_MAX, 8'hFF, 16'h8000, 1'b1,
                      32'h0000_0000));
    send_item(request(hrst_pkg::ACT_ADD, hrst_pkg::ID_MAX, '0, 16'h0001, 1'b0,
                      32'h1234_5678));
    send_item(request(hrst_pkg::ACT_ADD, '0, '0, 16'h0000, 1'b0, 32'h8000_0001));
    send_item(request(hrst_pkg::ACT_FIND, hrst_pkg::ID_MAX, '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_READ_ID, hrst_pkg::ID_MAX, '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_RELEASE_ID, hrst_pkg::ID_MAX, '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, 8'd1, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_RELEASE_SLOT, '0, 8'd2, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, 8'd2, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_RELEASE_ID, hrst_pkg::ID_W'(1), '0, '0, 1'b1, '0));
    send_item(request(hrst_pkg::ACT_READ_ID, hrst_pkg::ID_W'(1), '0, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_RELEASE_SLOT, '0, 8'd3, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, 8'd3, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, 8'd255, '0, 1'b0, '0));
    send_item(request(hrst_pkg::ACT_RELEASE_SLOT, '0, hrst_pkg::SLOT_W'(SLOTS), '0, 1'b1,
                      '0));
    send_item(request(hrst_pkg::ACT_READ_SLOT, '0, hrst_pkg::SLOT_W'(SLOTS - 1), '0, 1'b0,
                      '0));
    send_item(request(ACT_SPARE_6, hrst_pkg::ID_W'(2), '0, '0, 1'b0, '0));
    send_item(request(ACT_SPARE_7, hrst_pkg::ID_MAX, 8'd0, '0, 1'b1, '0));
    send_item(request(hrst_pkg::ACT_ADD, hrst_pkg::ID_W'(5), '0, 16'h0002, 1'b0,
                      32'hA5A5_0F0F));
    send_item(request(hrst_pkg::ACT_RELEASE_ID, '0, '0, '0, 1'b1, '0));
    send_item(request(hrst_pkg::ACT_FIND, hrst_pkg::ID_W'(7), '0, '0, 1'b0, '0));
    drain();

    // Random bursts: add-heavy ones fill the table until it overflows, lean ones empty it.
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = phase_modes[phase];
      sent      = 0;
      while (sent < PHASE_ITEMS) begin
        add_pct = add_mix[$urandom_range(0, 2)];
        for (int k = 0; k < BURST_ITEMS && sent < PHASE_ITEMS; k++) begin
          req = random_request(add_pct);
          if (req.action == hrst_pkg::ACT_ADD && req.record_id != '0) begin
            recent_ids.push_back(req.record_id);
            if (recent_ids.size() > 24) void'(recent_ids.pop_front());
          end
          send_item(req);
          sent++;
        end
      end
      drain();
    end

    idle_mode = IDLE_NONE;
    repeat (3 * (SLOTS + 2)) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

[files.f]
rtl/hrst_pkg.sv
rtl/hrst_cell.sv
rtl/hit_record_slot_table_unit.sv
bench/hrst_checker.sv
bench/testbench.sv
